FILE: hdl/nfcrp_pkg.sv
// nfcrp_pkg: types and constants shared by the nfc response frame parser
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package nfcrp_pkg;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONES = 8'hFF;
	localparam logic [7:0] MAX_FRAME_LEN_RESET = 8'd32;
	localparam logic [15:0] RECENT_RESET = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_LCS  = 3'd2,
		PH_TFI  = 3'd3,
		PH_DATA = 3'd4,
		PH_DCS  = 3'd5,
		PH_DONE = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		V_VALID   = 3'd0,
		V_ACK     = 3'd1,
		V_NACK    = 3'd2,
		V_EXT     = 3'd3,
		V_INVALID = 3'd4
	} verdict_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_read;
	} rx_item_t;

	typedef struct packed {
		item_kind_t item_kind;
		logic [7:0] data_byte;
		verdict_t   verdict;
		logic [7:0] payload_len;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/nfcrp_if.sv
// nfcrp_rx_if / nfcrp_result_if: valid/ready channels of the frame parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface nfcrp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_read;

	modport source (output valid, output rx_byte, output end_of_read, input ready);
	modport sink (input valid, input rx_byte, input end_of_read, output ready);
endinterface

interface nfcrp_result_if;
	logic       valid;
	logic       ready;
	logic       item_kind;
	logic [7:0] data_byte;
	logic [2:0] verdict;
	logic [7:0] payload_len;

	modport source (output valid, output item_kind, output data_byte, output verdict,
		output payload_len, input ready);
	modport sink (input valid, input item_kind, input data_byte, input verdict,
		input payload_len, output ready);
endinterface

`default_nettype wire

FILE: hdl/nfcrp_parser.sv
// nfcrp_parser: frame state and per-byte decode of one read transfer
// depends on nfcrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module nfcrp_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  nfcrp_pkg::rx_item_t  item,
	input  wire [7:0]            max_frame_len,
	output logic                 has_result,
	output nfcrp_pkg::result_t   result
);
	import nfcrp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] recent_q, recent_d;
	logic [7:0]  frame_len_q, frame_len_d;
	logic [7:0]  data_sum_q, data_sum_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [7:0]  frame_id_q, frame_id_d;
	logic [7:0]  b;
	logic        lcs_ok;
	logic        dcs_ok;
	logic [7:0]  left_dec;

	assign b        = item.rx_byte;
	assign lcs_ok   = (frame_len_q != BYTE_ZERO) && (frame_len_q <= max_frame_len)
		&& ((frame_len_q + b) == BYTE_ZERO);
	assign dcs_ok   = ((data_sum_q + b) == BYTE_ZERO);
	assign left_dec = bytes_left_q - 8'd1;

	// next state
	always_comb begin
		phase_d      = phase_q;
		recent_d     = recent_q;
		frame_len_d  = frame_len_q;
		data_sum_d   = data_sum_q;
		bytes_left_d = bytes_left_q;
		frame_id_d   = frame_id_q;
		case (phase_q)
			PH_HUNT: begin
				if (recent_q == 16'h0000 && b == BYTE_ONES) begin
					phase_d = PH_LEN;
				end else begin
					recent_d = {recent_q[7:0], b};
				end
			end
			PH_LEN: begin
				frame_len_d = b;
				phase_d     = PH_LCS;
			end
			PH_LCS: begin
				if (frame_len_q == BYTE_ZERO && b == BYTE_ONES) begin
					phase_d = PH_DONE;
				end else if (frame_len_q == BYTE_ONES && (b == BYTE_ZERO || b == BYTE_ONES)) begin
					phase_d = PH_DONE;
				end else if (lcs_ok) begin
					bytes_left_d = frame_len_q - 8'd1;
					phase_d      = PH_TFI;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_TFI: begin
				frame_id_d = b;
				data_sum_d = b;
				phase_d    = (bytes_left_q == BYTE_ZERO) ? PH_DCS : PH_DATA;
			end
			PH_DATA: begin
				data_sum_d   = data_sum_q + b;
				bytes_left_d = left_dec;
				if (left_dec == BYTE_ZERO) begin
					phase_d = PH_DCS;
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
		if (item.end_of_read) begin
			phase_d      = PH_HUNT;
			recent_d     = RECENT_RESET;
			frame_len_d  = BYTE_ZERO;
			data_sum_d   = BYTE_ZERO;
			bytes_left_d = BYTE_ZERO;
			frame_id_d   = BYTE_ZERO;
		end
	end

	// result of this byte
	always_comb begin
		has_result         = 1'b0;
		result.item_kind   = KIND_VERDICT;
		result.data_byte   = BYTE_ZERO;
		result.verdict     = V_INVALID;
		result.payload_len = BYTE_ZERO;
		case (phase_q)
			PH_LCS: begin
				if (frame_len_q == BYTE_ZERO && b == BYTE_ONES) begin
					has_result     = 1'b1;
					result.verdict = V_ACK;
				end else if (frame_len_q == BYTE_ONES && b == BYTE_ZERO) begin
					has_result     = 1'b1;
					result.verdict = V_NACK;
				end else if (frame_len_q == BYTE_ONES && b == BYTE_ONES) begin
					has_result     = 1'b1;
					result.verdict = V_EXT;
				end else if (!lcs_ok) begin
					has_result = 1'b1;
				end
			end
			PH_DATA: begin
				has_result       = 1'b1;
				result.item_kind = KIND_PAYLOAD;
				result.data_byte = b;
				result.verdict   = V_VALID;
			end
			PH_DCS: begin
				has_result = 1'b1;
				if (dcs_ok) begin
					result.data_byte   = frame_id_q;
					result.verdict     = V_VALID;
					result.payload_len = frame_len_q - 8'd1;
				end
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
		// transfer ends without a verdict
		if (item.end_of_read && phase_q != PH_DONE && phase_q != PH_DCS
			&& !(phase_q == PH_LCS && has_result)) begin
			has_result         = 1'b1;
			result.item_kind   = KIND_VERDICT;
			result.data_byte   = BYTE_ZERO;
			result.verdict     = V_INVALID;
			result.payload_len = BYTE_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			recent_q     <= RECENT_RESET;
			frame_len_q  <= BYTE_ZERO;
			data_sum_q   <= BYTE_ZERO;
			bytes_left_q <= BYTE_ZERO;
			frame_id_q   <= BYTE_ZERO;
		end else if (step) begin
			phase_q      <= phase_d;
			recent_q     <= recent_d;
			frame_len_q  <= frame_len_d;
			data_sum_q   <= data_sum_d;
			bytes_left_q <= bytes_left_d;
			frame_id_q   <= frame_id_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/nfc_response_frame_parser.sv
// nfc_response_frame_parser: top level of the response frame parser
// depends on nfcrp_pkg, nfcrp_if, nfcrp_parser
//
// Usage:
//   rx carries the bytes of one read transfer, end_of_read set on the last
//   byte. result carries payload bytes (item_kind 0) as they arrive and
//   exactly one verdict (item_kind 1) per transfer.
//   cfg_we/cfg_wdata write max_frame_len (reset 32); write only while idle.
// Timing:
//   a byte is captured in an input register, decoded in the next cycle and
//   its result, if any, lands in the output register, which drives valid on
//   result. One byte per cycle is sustained while result is ready, set by
//   the single decode stage between the two registers.
// Reset:
//   arst_n clears the frame state to hunting, empties both registers and
//   sets the limit to 32.
// Stall:
//   while result is held the output register keeps its item; the input
//   register takes one more byte only if it is empty, then rx ready drops.
`timescale 1ns / 1ps
`default_nettype none

module nfc_response_frame_parser (
	input  wire                    clk,
	input  wire                    arst_n,
	nfcrp_rx_if.sink               rx,
	nfcrp_result_if.source         result,
	input  wire                    cfg_we,
	input  wire [7:0]              cfg_wdata
);
	import nfcrp_pkg::*;

	logic      valid_s1;
	rx_item_t  item_s1;
	logic      valid_s2;
	result_t   item_s2;
	logic [7:0] max_frame_len_q;
	logic      advance;
	logic      has_result;
	result_t   dec_result;

	assign advance  = valid_s1 && (!valid_s2 || result.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= MAX_FRAME_LEN_RESET;
		end else if (cfg_we) begin
			max_frame_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1.rx_byte     <= rx.rx_byte;
			item_s1.end_of_read <= rx.end_of_read;
		end
	end

	nfcrp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.max_frame_len (max_frame_len_q),
		.has_result    (has_result),
		.result        (dec_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= has_result;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			item_s2 <= dec_result;
		end
	end

	assign result.valid       = valid_s2;
	assign result.item_kind   = item_s2.item_kind;
	assign result.data_byte   = item_s2.data_byte;
	assign result.verdict     = item_s2.verdict;
	assign result.payload_len = item_s2.payload_len;

endmodule

`default_nettype wire
